FILE: src/gbr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_pkg: shared types and constants for the glyph bitmap blend renderer
// Register indexes, reset values, pixel record between unpacker and blender,
// and the coverage scale and reciprocal tables.
// ----------------------------------------------------------------------------
package gbr_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int QUEUE_DEPTH    = 4;

	// Reciprocal scaling: floor(n / m) = (n * recip(m)) >> RECIP_SHIFT for n < 2^16
	localparam int RECIP_SHIFT = 25;
	localparam int RECIP_BITS  = 26;

	// Item kinds
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_DATA  = 1'b1;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_BPP  = 3'd0,
		REG_FG_R = 3'd1,
		REG_FG_G = 3'd2,
		REG_FG_B = 3'd3,
		REG_BG_R = 3'd4,
		REG_BG_G = 3'd5,
		REG_BG_B = 3'd6
	} reg_idx_t;

	localparam logic [3:0] BPP_RESET = 4'd1;
	localparam logic [7:0] FG_RESET  = 8'hFF;
	localparam logic [7:0] BG_RESET  = 8'h00;

	// Coverage class of one pixel
	typedef enum logic [1:0] {
		CLS_CLEAR = 2'd0,
		CLS_FULL  = 2'd1,
		CLS_BLEND = 2'd2
	} cls_t;

	// Pixel record handed from the unpacker to the blender
	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [7:0]  p;
		cls_t        cls;
		logic        done;
		logic        last;
	} pix_t;

	// Colour and depth settings for the blender; the unpacker sees only the depth
	typedef struct packed {
		logic [3:0] bpp;
		logic [7:0] fg_r;
		logic [7:0] fg_g;
		logic [7:0] fg_b;
		logic [7:0] bg_r;
		logic [7:0] bg_g;
		logic [7:0] bg_b;
	} cfg_t;

	// Clamp the depth register into 1..8
	function automatic logic [3:0] eff_bpp(input logic [3:0] raw);
		logic [3:0] b;
		b = raw;
		if (raw == 4'd0) begin
			b = 4'd1;
		end else if (raw > 4'd8) begin
			b = 4'd8;
		end
		return b;
	endfunction

	// Full-scale coverage for a clamped depth
	function automatic logic [7:0] pix_max(input logic [3:0] bpp);
		logic [7:0] m;
		unique case (bpp)
			4'd1: m = 8'h01;
			4'd2: m = 8'h03;
			4'd3: m = 8'h07;
			4'd4: m = 8'h0F;
			4'd5: m = 8'h1F;
			4'd6: m = 8'h3F;
			4'd7: m = 8'h7F;
			default: m = 8'hFF;
		endcase
		return m;
	endfunction

	// ceil(2^RECIP_SHIFT / full scale) for a clamped depth
	function automatic logic [RECIP_BITS-1:0] recip(input logic [3:0] bpp);
		logic [RECIP_BITS-1:0] r;
		unique case (bpp)
			4'd1: r = RECIP_BITS'(33554432);
			4'd2: r = RECIP_BITS'(11184811);
			4'd3: r = RECIP_BITS'(4793491);
			4'd4: r = RECIP_BITS'(2236963);
			4'd5: r = RECIP_BITS'(1082402);
			4'd6: r = RECIP_BITS'(532611);
			4'd7: r = RECIP_BITS'(264209);
			default: r = RECIP_BITS'(131587);
		endcase
		return r;
	endfunction

endpackage

FILE: src/gbr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_front: item intake and bitmap unpacker
// Holds the glyph box; unless a pixel is refused, shifts one bit per cycle
// into the pixel being gathered and pushes a classified record per pixel.
// ----------------------------------------------------------------------------
module gbr_front #(
	parameter int COORD_BITS = gbr_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [3:0]         bpp,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [15:0] glyph_left,
	input  logic signed [15:0] glyph_top,
	input  logic [7:0]         box_width,
	input  logic [7:0]         box_height,
	input  logic [7:0]         data_byte,
	output logic               push_valid,
	output gbr_pkg::pix_t      push_data,
	input  logic               push_ready
);

	logic                  busy_q;
	logic [7:0]            byte_q;
	logic [3:0]            rem_q;
	logic [COORD_BITS-1:0] box_left_q;
	logic [7:0]            box_cols_q;
	logic [7:0]            cur_col_q;
	logic [COORD_BITS-1:0] cur_row_y_q;
	logic [7:0]            rows_left_q;
	logic [7:0]            partial_q;
	logic [3:0]            pcount_q;

	logic [7:0]            part_sh;
	logic [3:0]            cnt_inc;
	logic                  complete;
	logic                  step;
	logic [7:0]            col_inc;
	logic                  row_end;
	logic [7:0]            rows_next;
	logic [3:0]            rem_next;
	logic                  fin;
	logic [7:0]            maxv;
	logic [7:0]            p_val;
	logic [7:0]            rows_eff;
	logic                  accept;
	logic [COORD_BITS-1:0] x_sum;
	logic [COORD_BITS+15:0] x_ext;
	logic [COORD_BITS+15:0] y_ext;
	logic [COORD_BITS+15:0] left_ext;
	logic [COORD_BITS+15:0] top_ext;

	// Shift the next bitmap bit into the pixel being gathered
	always_comb begin
		part_sh   = {partial_q[6:0], byte_q[7]};
		cnt_inc   = pcount_q + 4'd1;
		complete  = busy_q && (cnt_inc >= bpp);
		step      = busy_q && (!complete || push_ready);
		col_inc   = cur_col_q + 8'd1;
		row_end   = complete && (col_inc >= box_cols_q);
		rows_next = row_end ? (rows_left_q - 8'd1) : rows_left_q;
		rem_next  = rem_q - 4'd1;
		fin       = step && ((rem_next == 4'd0) || (rows_next == 8'd0));
		rows_eff  = fin ? rows_next : rows_left_q;
		maxv      = gbr_pkg::pix_max(bpp);
		p_val     = part_sh & maxv;
	end

	assign in_ready = !busy_q || fin;
	assign accept   = in_valid && in_ready;

	// Build the pixel record: coordinates wrap at the coordinate width
	always_comb begin
		x_sum    = box_left_q + {{(COORD_BITS-8){1'b0}}, cur_col_q};
		x_ext    = {16'b0, x_sum};
		y_ext    = {16'b0, cur_row_y_q};
		left_ext = {{COORD_BITS{glyph_left[15]}}, glyph_left};
		top_ext  = {{COORD_BITS{glyph_top[15]}}, glyph_top};
		push_data.x    = x_ext[15:0];
		push_data.y    = y_ext[15:0];
		push_data.p    = p_val;
		push_data.done = row_end && (rows_next == 8'd0);
		push_data.last = (rows_next == 8'd0) || (rem_next < bpp);
		if (p_val == 8'd0) begin
			push_data.cls = gbr_pkg::CLS_CLEAR;
		end else if (p_val == maxv) begin
			push_data.cls = gbr_pkg::CLS_FULL;
		end else begin
			push_data.cls = gbr_pkg::CLS_BLEND;
		end
	end

	assign push_valid = complete;

	// Advance the unpacker, then take a new item over the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			byte_q      <= '0;
			rem_q       <= '0;
			box_left_q  <= '0;
			box_cols_q  <= '0;
			cur_col_q   <= '0;
			cur_row_y_q <= '0;
			rows_left_q <= '0;
			partial_q   <= '0;
			pcount_q    <= '0;
		end else begin
			if (step) begin
				byte_q <= {byte_q[6:0], 1'b0};
				rem_q  <= rem_next;
				if (complete) begin
					partial_q <= '0;
					pcount_q  <= '0;
					cur_col_q <= row_end ? 8'd0 : col_inc;
					if (row_end) begin
						cur_row_y_q <= cur_row_y_q + COORD_BITS'(1);
						rows_left_q <= rows_next;
					end
				end else begin
					partial_q <= part_sh;
					pcount_q  <= cnt_inc;
				end
				if (fin) begin
					busy_q <= 1'b0;
				end
			end
			if (accept) begin
				if (kind == gbr_pkg::KIND_START) begin
					box_left_q  <= left_ext[COORD_BITS-1:0];
					cur_row_y_q <= top_ext[COORD_BITS-1:0];
					box_cols_q  <= box_width;
					cur_col_q   <= '0;
					rows_left_q <= (box_width == 8'd0) ? 8'd0 : box_height;
					partial_q   <= '0;
					pcount_q    <= '0;
					busy_q      <= 1'b0;
				end else if (rows_eff != 8'd0) begin
					byte_q <= data_byte;
					rem_q  <= 4'd8;
					busy_q <= 1'b1;
				end
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pcount_q <= 4'd8)
		else $error("gathered bit count beyond eight");

	a_busy_has_rows: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (rows_left_q != 8'd0))
		else $error("unpacking with no rows left in the box");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(push_valid && !push_ready) |=> ($stable(byte_q) && $stable(rem_q) && busy_q))
		else $error("unpacker moved on while its pixel was refused");

endmodule

FILE: src/gbr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_queue: pixel record queue
// Short first-in first-out buffer that lets the unpacker and the blender
// stall independently.
// ----------------------------------------------------------------------------
module gbr_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  gbr_pkg::pix_t push_data,
	output logic          push_ready,
	output logic          pop_valid,
	output gbr_pkg::pix_t pop_data,
	input  logic          pop_ready
);

	localparam int DEPTH = gbr_pkg::QUEUE_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	gbr_pkg::pix_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          push;
	logic          pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Store a transfer at the write pointer
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue occupancy beyond depth");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CW'(1)))
		else $error("occupancy missed a transfer in");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		((count_q == '0) || (count_q == CW'(DEPTH))) |-> (wr_ptr_q == rd_ptr_q))
		else $error("pointers disagree with occupancy");

endmodule

FILE: src/gbr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbr_back: colour blender
// Two-stage pipeline: weighted channel sums, then division by the coverage
// scale through a reciprocal multiply, with the result held for transfer.
// ----------------------------------------------------------------------------
module gbr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  gbr_pkg::cfg_t      cfg,
	input  logic               pop_valid,
	input  gbr_pkg::pix_t      pop_data,
	output logic               pop_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               draw,
	output logic               glyph_done,
	output logic               last
);

	localparam int PB = 16 + gbr_pkg::RECIP_BITS;
	localparam int SH = gbr_pkg::RECIP_SHIFT;

	logic          v_s1;
	gbr_pkg::pix_t pix_s1;
	logic [15:0]   nr_s1;
	logic [15:0]   ng_s1;
	logic [15:0]   nb_s1;

	logic          v_s2;
	logic [15:0]   x_s2;
	logic [15:0]   y_s2;
	logic [7:0]    r_s2;
	logic [7:0]    g_s2;
	logic [7:0]    b_s2;
	logic          draw_s2;
	logic          done_s2;
	logic          last_s2;

	logic          rdy1;
	logic          rdy2;
	logic [7:0]    maxv;
	logic [7:0]    inv;
	logic [16:0]   sr;
	logic [16:0]   sg;
	logic [16:0]   sb;
	logic [gbr_pkg::RECIP_BITS-1:0] rcp;
	logic [PB-1:0] pr;
	logic [PB-1:0] pg;
	logic [PB-1:0] pbl;

	assign rdy2      = !v_s2 || out_ready;
	assign rdy1      = !v_s1 || rdy2;
	assign pop_ready = rdy1;

	// Weighted sums fg*p + bg*(max-p) per channel
	always_comb begin
		maxv = gbr_pkg::pix_max(cfg.bpp);
		inv  = maxv - pop_data.p;
		sr   = 17'({8'b0, cfg.fg_r} * {8'b0, pop_data.p})
			+ 17'({8'b0, cfg.bg_r} * {8'b0, inv});
		sg   = 17'({8'b0, cfg.fg_g} * {8'b0, pop_data.p})
			+ 17'({8'b0, cfg.bg_g} * {8'b0, inv});
		sb   = 17'({8'b0, cfg.fg_b} * {8'b0, pop_data.p})
			+ 17'({8'b0, cfg.bg_b} * {8'b0, inv});
	end

	// Divide by the full scale through its reciprocal
	always_comb begin
		rcp = gbr_pkg::recip(cfg.bpp);
		pr  = {{gbr_pkg::RECIP_BITS{1'b0}}, nr_s1} * {16'b0, rcp};
		pg  = {{gbr_pkg::RECIP_BITS{1'b0}}, ng_s1} * {16'b0, rcp};
		pbl = {{gbr_pkg::RECIP_BITS{1'b0}}, nb_s1} * {16'b0, rcp};
	end

	// Stage one: hold the sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && pop_valid) begin
			pix_s1 <= pop_data;
			nr_s1  <= sr[15:0];
			ng_s1  <= sg[15:0];
			nb_s1  <= sb[15:0];
		end
	end

	// Stage two: pick the colour and hold it for transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			x_s2    <= pix_s1.x;
			y_s2    <= pix_s1.y;
			done_s2 <= pix_s1.done;
			last_s2 <= pix_s1.last;
			unique case (pix_s1.cls)
				gbr_pkg::CLS_FULL: begin
					r_s2    <= cfg.fg_r;
					g_s2    <= cfg.fg_g;
					b_s2    <= cfg.fg_b;
					draw_s2 <= 1'b1;
				end
				gbr_pkg::CLS_BLEND: begin
					r_s2    <= pr[SH+7:SH];
					g_s2    <= pg[SH+7:SH];
					b_s2    <= pbl[SH+7:SH];
					draw_s2 <= 1'b1;
				end
				default: begin
					r_s2    <= '0;
					g_s2    <= '0;
					b_s2    <= '0;
					draw_s2 <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid  = v_s2;
	assign pixel_x    = $signed(x_s2);
	assign pixel_y    = $signed(y_s2);
	assign red        = r_s2;
	assign green      = g_s2;
	assign blue       = b_s2;
	assign draw       = draw_s2;
	assign glyph_done = done_s2;
	assign last       = last_s2;

endmodule

FILE: src/glyph_bitmap_blend_render.sv
`timescale 1ns / 1ps
// Throughput: the unpacker consumes one bitmap bit per cycle while the queue takes
// its pixels; it accepts a new item (start, data or ignored byte) while idle or as it
// finishes the current byte.
// The blender pipeline, whose last stage is the output register, sits behind a 4-entry queue.
// Reset (arst_n, asynchronous): control state and configuration registers return to
// their reset values at once; queue storage and pipeline data are not reset and need no clearing pass.
// ----------------------------------------------------------------------------
// glyph_bitmap_blend_render: antialiased glyph bitmap blit
// Configuration registers, the unpacker front, the pixel queue and the colour
// blender back.
// ----------------------------------------------------------------------------
module glyph_bitmap_blend_render #(
	parameter int COORD_BITS = gbr_pkg::COORD_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic signed [15:0] glyph_left,
	input  logic signed [15:0] glyph_top,
	input  logic [7:0]         box_width,
	input  logic [7:0]         box_height,
	input  logic [7:0]         data_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] pixel_x,
	output logic signed [15:0] pixel_y,
	output logic [7:0]         red,
	output logic [7:0]         green,
	output logic [7:0]         blue,
	output logic               draw,
	output logic               glyph_done,
	output logic               last
);

	logic [3:0]    bpp_q;
	logic [7:0]    fg_r_q;
	logic [7:0]    fg_g_q;
	logic [7:0]    fg_b_q;
	logic [7:0]    bg_r_q;
	logic [7:0]    bg_g_q;
	logic [7:0]    bg_b_q;
	gbr_pkg::cfg_t cfg;

	logic          push_valid;
	gbr_pkg::pix_t push_data;
	logic          push_ready;
	logic          pop_valid;
	gbr_pkg::pix_t pop_data;
	logic          pop_ready;

	// Take configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q  <= gbr_pkg::BPP_RESET;
			fg_r_q <= gbr_pkg::FG_RESET;
			fg_g_q <= gbr_pkg::FG_RESET;
			fg_b_q <= gbr_pkg::FG_RESET;
			bg_r_q <= gbr_pkg::BG_RESET;
			bg_g_q <= gbr_pkg::BG_RESET;
			bg_b_q <= gbr_pkg::BG_RESET;
		end else if (cfg_we) begin
			unique case (gbr_pkg::reg_idx_t'(cfg_index))
				gbr_pkg::REG_BPP:  bpp_q  <= cfg_data[3:0];
				gbr_pkg::REG_FG_R: fg_r_q <= cfg_data;
				gbr_pkg::REG_FG_G: fg_g_q <= cfg_data;
				gbr_pkg::REG_FG_B: fg_b_q <= cfg_data;
				gbr_pkg::REG_BG_R: bg_r_q <= cfg_data;
				gbr_pkg::REG_BG_G: bg_g_q <= cfg_data;
				gbr_pkg::REG_BG_B: bg_b_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Clamp depth and bundle the settings
	always_comb begin
		cfg.bpp  = gbr_pkg::eff_bpp(bpp_q);
		cfg.fg_r = fg_r_q;
		cfg.fg_g = fg_g_q;
		cfg.fg_b = fg_b_q;
		cfg.bg_r = bg_r_q;
		cfg.bg_g = bg_g_q;
		cfg.bg_b = bg_b_q;
	end

	gbr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.bpp        (cfg.bpp),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.glyph_left (glyph_left),
		.glyph_top  (glyph_top),
		.box_width  (box_width),
		.box_height (box_height),
		.data_byte  (data_byte),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready)
	);

	gbr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_data  (push_data),
		.push_ready (push_ready),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready)
	);

	gbr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.pop_valid  (pop_valid),
		.pop_data   (pop_data),
		.pop_ready  (pop_ready),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.draw       (draw),
		.glyph_done (glyph_done),
		.last       (last)
	);

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: glyph bitmap blend renderer testbench
// Sends glyph start and bitmap byte transfers with random gaps and output
// stalls, predicts every pixel with a software unpacker and blender, and
// checks each output transfer in order against the oldest predicted pixel.
// ----------------------------------------------------------------------------

// One predicted or observed pixel
typedef struct packed {
	logic [15:0] x;
	logic [15:0] y;
	logic [7:0]  r;
	logic [7:0]  g;
	logic [7:0]  b;
	logic        draw;
	logic        done;
	logic        last;
} pixel_t;

class glyph_scoreboard;
	// Register copies
	logic [3:0]  bpp_raw;
	logic [7:0]  fg [3];
	logic [7:0]  bg [3];
	// Glyph walk state
	logic [15:0] left_x;
	logic [15:0] row_y;
	int          cols;
	int          col;
	int          rows_left;
	logic [7:0]  part_bits;
	logic [3:0]  part_count;
	// Pixels still to come out of the block
	pixel_t      pending_pixels[$];
	int          errors;
	int          pixels_seen;
	int          glyphs;

	function new();
		bpp_raw = gbr_pkg::BPP_RESET;
		for (int c = 0; c < 3; c++) begin
			fg[c] = gbr_pkg::FG_RESET;
			bg[c] = gbr_pkg::BG_RESET;
		end
		left_x = '0;
		row_y = '0;
		cols = 0;
		col = 0;
		rows_left = 0;
		part_bits = '0;
		part_count = '0;
		errors = 0;
		pixels_seen = 0;
		glyphs = 0;
	endfunction

	// Clamp the depth register into 1..8
	function int depth();
		if (bpp_raw == 4'd0) return 1;
		if (bpp_raw > 4'd8) return 8;
		return bpp_raw;
	endfunction

	function logic [7:0] mix(int f, int b, int p, int m);
		return 8'((f * p + b * (m - p)) / m);
	endfunction

	function void set_reg(logic [2:0] idx, logic [7:0] val);
		case (idx)
			gbr_pkg::REG_BPP:  bpp_raw = val[3:0];
			gbr_pkg::REG_FG_R: fg[0] = val;
			gbr_pkg::REG_FG_G: fg[1] = val;
			gbr_pkg::REG_FG_B: fg[2] = val;
			gbr_pkg::REG_BG_R: bg[0] = val;
			gbr_pkg::REG_BG_G: bg[1] = val;
			gbr_pkg::REG_BG_B: bg[2] = val;
			default: ;
		endcase
	endfunction

	// Predict the pixels of one accepted transfer; return 0 if it is ignored
	function bit note_transfer(logic k, logic [15:0] gl, logic [15:0] gt,
			logic [7:0] w, logic [7:0] h, logic [7:0] d);
		int     bits;
		int     full;
		int     p;
		int     bi;
		bit     have;
		pixel_t px;
		pixel_t held;
		if (k == gbr_pkg::KIND_START) begin
			left_x = gl;
			row_y = gt;
			cols = w;
			col = 0;
			rows_left = (w == 8'd0) ? 0 : int'(h);
			part_bits = '0;
			part_count = '0;
			glyphs++;
			return 1'b1;
		end
		if (rows_left == 0) return 1'b0;
		bits = depth();
		full = (1 << bits) - 1;
		have = 1'b0;
		held = '0;
		for (bi = 7; bi >= 0 && rows_left != 0; bi--) begin
			part_bits = {part_bits[6:0], d[bi]};
			part_count = part_count + 4'd1;
			if (part_count >= bits) begin
				p = part_bits & full;
				part_bits = '0;
				part_count = '0;
				px = '0;
				if (p == full) begin
					px.r = fg[0];
					px.g = fg[1];
					px.b = fg[2];
					px.draw = 1'b1;
				end else if (p != 0) begin
					px.r = mix(fg[0], bg[0], p, full);
					px.g = mix(fg[1], bg[1], p, full);
					px.b = mix(fg[2], bg[2], p, full);
					px.draw = 1'b1;
				end
				px.x = left_x + 16'(col);
				px.y = row_y;
				// Advance along the row, then down the box
				col++;
				if (col >= cols) begin
					col = 0;
					row_y = row_y + 16'd1;
					rows_left--;
					px.done = (rows_left == 0);
				end
				if (have) pending_pixels.push_back(held);
				held = px;
				have = 1'b1;
			end
		end
		// Drop padding once the box is complete
		if (rows_left == 0) begin
			part_bits = '0;
			part_count = '0;
		end
		if (have) begin
			held.last = 1'b1;
			pending_pixels.push_back(held);
		end
		return 1'b1;
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 30) $display("mismatch: %s", msg);
	endtask

	task check_pixel(pixel_t got);
		pixel_t want;
		pixels_seen++;
		if (pending_pixels.size() == 0) begin
			report($sformatf("pixel at x=%0h y=%0h with none expected", got.x, got.y));
			return;
		end
		want = pending_pixels.pop_front();
		if (got.x !== want.x)
			report($sformatf("pixel_x got %h want %h", got.x, want.x));
		if (got.y !== want.y)
			report($sformatf("pixel_y got %h want %h", got.y, want.y));
		if (got.r !== want.r)
			report($sformatf("red got %h want %h at x=%h", got.r, want.r, want.x));
		if (got.g !== want.g)
			report($sformatf("green got %h want %h at x=%h", got.g, want.g, want.x));
		if (got.b !== want.b)
			report($sformatf("blue got %h want %h at x=%h", got.b, want.b, want.x));
		if (got.draw !== want.draw)
			report($sformatf("draw got %b want %b at x=%h", got.draw, want.draw, want.x));
		if (got.done !== want.done)
			report($sformatf("glyph_done got %b want %b at x=%h", got.done, want.done, want.x));
		if (got.last !== want.last)
			report($sformatf("last got %b want %b at x=%h", got.last, want.last, want.x));
	endtask
endclass

module tb;
	localparam int         IDLE_PCT    = 36;
	localparam int         SETTLE      = 32;
	localparam int         TOTAL_ITEMS = 460;
	localparam int         HOLD_PHASE  = 3;
	localparam int         HOLD_CYCLES = 300;
	localparam int         MAX_BYTES   = 24;
	localparam logic [2:0] REG_UNUSED  = 3'd7;

	logic        clk;
	logic        arst_n     = 1'b0;
	logic        cfg_we     = 1'b0;
	logic [2:0]  cfg_index  = '0;
	logic [7:0]  cfg_data   = '0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic        kind       = gbr_pkg::KIND_START;
	logic [15:0] glyph_left = '0;
	logic [15:0] glyph_top  = '0;
	logic [7:0]  box_width  = '0;
	logic [7:0]  box_height = '0;
	logic [7:0]  data_byte  = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [15:0] pixel_x;
	logic [15:0] pixel_y;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        draw;
	logic        glyph_done;
	logic        last;

	glyph_scoreboard sb;
	pixel_t          seen;
	int              effective  = 0;
	int              settings   = 0;
	logic            steady     = 1'b0;
	logic            hold_req   = 1'b0;
	logic            out_hold   = 1'b0;

	glyph_bitmap_blend_render u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.glyph_left (glyph_left),
		.glyph_top  (glyph_top),
		.box_width  (box_width),
		.box_height (box_height),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.pixel_x    (pixel_x),
		.pixel_y    (pixel_y),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.draw       (draw),
		.glyph_done (glyph_done),
		.last       (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

	// Check each output transfer and pick the next ready level
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen.x = pixel_x;
			seen.y = pixel_y;
			seen.r = red;
			seen.g = green;
			seen.b = blue;
			seen.draw = draw;
			seen.done = glyph_done;
			seen.last = last;
			sb.check_pixel(seen);
		end
		out_ready <= !out_hold && (steady || $urandom_range(99) >= IDLE_PCT);
	end

	// Hold off the receiver for a long stretch so the block backs up
	initial begin
		wait (hold_req);
		@(posedge clk);
		out_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		out_hold <= 1'b0;
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one transfer, at times after a random gap, and wait for it to go in
	task automatic send(logic k, logic [15:0] gl, logic [15:0] gt,
			logic [7:0] w, logic [7:0] h, logic [7:0] d);
		if (!steady && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		glyph_left <= gl;
		glyph_top <= gt;
		box_width <= w;
		box_height <= h;
		data_byte <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (sb.note_transfer(k, gl, gt, w, h, d)) effective++;
		steady <= (effective >= 180 && effective < 300);
	endtask

	task automatic send_start(logic [15:0] gl, logic [15:0] gt, logic [7:0] w, logic [7:0] h);
		send(gbr_pkg::KIND_START, gl, gt, w, h, 8'($urandom));
	endtask

	task automatic send_byte(logic [7:0] d);
		send(gbr_pkg::KIND_DATA, 16'($urandom), 16'($urandom), 8'($urandom), 8'($urandom), d);
	endtask

	// Drop valid and wait until the block has gone quiet
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_cfg(logic [2:0] idx, logic [7:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic configure(logic [7:0] bpp_val, logic [7:0] fr, logic [7:0] fgn,
			logic [7:0] fb, logic [7:0] br, logic [7:0] bgn, logic [7:0] bb);
		settle();
		write_cfg(gbr_pkg::REG_BPP, bpp_val);
		write_cfg(gbr_pkg::REG_FG_R, fr);
		write_cfg(gbr_pkg::REG_FG_G, fgn);
		write_cfg(gbr_pkg::REG_FG_B, fb);
		write_cfg(gbr_pkg::REG_BG_R, br);
		write_cfg(gbr_pkg::REG_BG_G, bgn);
		write_cfg(gbr_pkg::REG_BG_B, bb);
		write_cfg(REG_UNUSED, 8'($urandom));
		cfg_we <= 1'b0;
		settings++;
	endtask

	task automatic run_directed();
		// Reset settings: stray byte, then a box wrapping in x and y
		send_byte(8'h5A);
		send_start(16'h7FFE, 16'h7FFF, 8'd3, 8'd2);
		send_byte(8'hA5);
		send_byte(8'hFF);
		// Empty boxes swallow their bytes
		send_start(16'h8000, 16'hFFFF, 8'd0, 8'd5);
		send_byte(8'hFF);
		send_start(16'h0000, 16'h0000, 8'd4, 8'd0);
		send_byte(8'hFF);
		// Largest box, aborted by a fresh start with padding after it
		send_start(16'h1234, 16'h8000, 8'd255, 8'd255);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_start(16'h0010, 16'h0020, 8'd2, 8'd1);
		send_byte(8'h80);
		// Two bits: clear, two blend levels and full
		configure(8'h02, 8'hC8, 8'h64, 8'h32, 8'h0A, 8'h14, 8'h1E);
		send_start(16'd100, -16'sd5, 8'd4, 8'd1);
		send_byte(8'h1B);
		// Three bits, high nibble set, leaving a part pixel behind
		configure(8'hF3, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h7F, 8'h00);
		send_start(-16'sd200, 16'd40, 8'd8, 8'd1);
		send_byte(8'hE4);
		// Narrow the depth while that pixel is half gathered
		configure(8'h01, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'h7F, 8'h00);
		send_byte(8'h6C);
		// Depth zero acts as one
		configure(8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00);
		send_start(16'h0000, 16'h0000, 8'd5, 8'd1);
		send_byte(8'hA8);
		// Depth fifteen acts as eight, colours at opposite extremes
		configure(8'h0F, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF);
		send_start(16'hFFFF, 16'hFFFF, 8'd3, 8'd1);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h80);
	endtask

	function automatic logic [7:0] rand_bpp();
		logic [3:0] b;
		if ($urandom_range(3) != 0) b = 4'($urandom_range(1, 8));
		else b = 4'($urandom_range(0, 15));
		return {4'($urandom), b};
	endfunction

	function automatic logic [7:0] rand_level();
		case ($urandom_range(5))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic run_random();
		int phase;
		int n_glyphs;
		int g;
		int w;
		int h;
		int nbytes;
		int n;
		int mode;
		int open_bytes;
		phase = 0;
		open_bytes = 0;
		while (effective < TOTAL_ITEMS) begin
			phase++;
			configure(rand_bpp(), rand_level(), rand_level(), rand_level(),
				rand_level(), rand_level(), rand_level());
			if (phase == HOLD_PHASE) hold_req <= 1'b1;
			// Carry on with a glyph left open under the new setting
			if (open_bytes > 0 && $urandom_range(1) == 1) begin
				n = $urandom_range(1, (open_bytes > MAX_BYTES) ? MAX_BYTES : open_bytes);
				repeat (n) send_byte(rand_byte());
			end
			open_bytes = 0;
			n_glyphs = (phase == HOLD_PHASE) ? 4 : $urandom_range(1, 3);
			for (g = 0; g < n_glyphs; g++) begin
				w = $urandom_range(1, 10);
				h = $urandom_range(1, 5);
				if (phase == HOLD_PHASE) begin
					w = 8;
					h = 4;
				end else begin
					case ($urandom_range(15))
						0: w = 0;
						1: h = 0;
						2: begin
							w = $urandom_range(11, 255);
							h = $urandom_range(6, 255);
						end
						default: ;
					endcase
				end
				nbytes = (w * h * sb.depth() + 7) / 8;
				mode = $urandom_range(9);
				n = nbytes;
				if (mode == 0 && nbytes > 0) n = $urandom_range(0, nbytes - 1);
				else if (mode == 1) n = nbytes + $urandom_range(1, 3);
				if (n > MAX_BYTES) n = MAX_BYTES;
				send_start(16'($urandom), 16'($urandom), 8'(w), 8'(h));
				repeat (n) send_byte(rand_byte());
				open_bytes = (nbytes > n) ? nbytes - n : 0;
			end
		end
	endtask

	initial begin
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random();
		settle();
		$display("Covered %0d glyph boxes, %0d transfers in and %0d pixels checked",
			sb.glyphs, effective, sb.pixels_seen);
		$display("over %0d depth and colour settings, with stalls and a long output hold-off.",
			settings);
		if (sb.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

FILE: glyph_bitmap_blend_render.f
src/gbr_pkg.sv
src/gbr_front.sv
src/gbr_queue.sv
src/gbr_back.sv
src/glyph_bitmap_blend_render.sv
test/tb.sv
